// ===== src/cov_pkg.sv =====
// ----------------------------------------------------------------------------
// cov_pkg: shared types and constants
// Word formats, register indexes and sideband flags of the orbit velocity unit.
// ----------------------------------------------------------------------------
package cov_pkg;

  localparam int COV_DW   = 32;  // field width
  localparam int COV_FB   = 16;  // fraction bits
  localparam int COV_IDXW = 2;   // register index width

  localparam logic [COV_IDXW-1:0] COV_REG_GRAV = 2'd0;
  localparam logic [COV_IDXW-1:0] COV_REG_MASS = 2'd1;
  localparam logic [COV_IDXW-1:0] COV_REG_DRAD = 2'd2;

  localparam logic [COV_DW-1:0] COV_REG_RESET = 32'd65536;

  typedef struct packed {
    logic signed [COV_DW-1:0] pos_x;
    logic signed [COV_DW-1:0] pos_y;
    logic                     last_in;
  } cov_in_t;

  typedef struct packed {
    logic signed [COV_DW-1:0] vel_x;
    logic signed [COV_DW-1:0] vel_y;
    logic                     last_out;
  } cov_out_t;

  // per-word flags that ride alongside the datapath
  typedef struct packed {
    logic nx;    // vel_y negative
    logic ny;    // vel_x negative
    logic mx0;   // |x| is zero
    logic my0;   // |y| is zero
    logic last;
  } cov_flags_t;

endpackage

// ===== src/cov_mul.sv =====
// ----------------------------------------------------------------------------
// cov_mul: two-stage pipelined multiplier
// Splits both operands into PW-bit chunks, registers the partial products,
// then registers their shifted sum.
// ----------------------------------------------------------------------------
module cov_mul #(
  parameter int AW  = 32,
  parameter int BW  = 32,
  parameter int PW  = 32,
  parameter int SBW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [AW-1:0]     a_i,
  input  logic [BW-1:0]     b_i,
  input  logic [SBW-1:0]    sb_i,
  output logic              vld_o,
  output logic [AW+BW-1:0]  p_o,
  output logic [SBW-1:0]    sb_o
);

  localparam int NA   = (AW + PW - 1) / PW;
  localparam int NB   = (BW + PW - 1) / PW;
  localparam int AXW  = NA * PW;
  localparam int BXW  = NB * PW;
  localparam int SUMW = (NA + NB) * PW;

  logic [AXW-1:0]    a_ext;
  logic [BXW-1:0]    b_ext;
  logic [2*PW-1:0]   pp_r [NA*NB];
  logic [SUMW-1:0]   acc;
  logic [AW+BW-1:0]  p_r;
  logic              v1_r, v2_r;
  logic [SBW-1:0]    sb1_r, sb2_r;

  assign a_ext = AXW'(a_i);
  assign b_ext = BXW'(b_i);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i*NB+j] <= a_ext[i*PW +: PW] * b_ext[j*PW +: PW];
        end
      end
      sb1_r <= sb_i;
      p_r   <= acc[AW+BW-1:0];
      sb2_r <= sb1_r;
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SUMW'(pp_r[i*NB+j]) << ((i + j) * PW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
    end
  end

  assign vld_o = v2_r;
  assign p_o   = p_r;
  assign sb_o  = sb2_r;

endmodule

// ===== src/cov_sqrt.sv =====
// ----------------------------------------------------------------------------
// cov_sqrt: pipelined integer square root
// One result bit per stage, digit-by-digit restoring method.
// ----------------------------------------------------------------------------
module cov_sqrt #(
  parameter int IW  = 64,
  parameter int SBW = 1,
  localparam int IWE = IW + IW % 2,
  localparam int OW  = IWE / 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [IW-1:0]   rad_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            vld_o,
  output logic [OW-1:0]   root_o,
  output logic [SBW-1:0]  sb_o
);

  localparam int RMW = OW + 2;

  logic             v_r    [1:OW];
  logic [RMW-1:0]   rem_r  [1:OW];
  logic [OW-1:0]    root_r [1:OW];
  logic [IWE-1:0]   op_r   [1:OW];
  logic [SBW-1:0]   sb_r   [1:OW];

  for (genvar s = 0; s < OW; s++) begin : g_stage
    logic             v_c;
    logic [RMW-1:0]   rem_c, rem_sh, trial, rem_nxt;
    logic [OW-1:0]    root_c, root_nxt;
    logic [IWE-1:0]   op_c;
    logic [SBW-1:0]   sb_c;

    if (s == 0) begin : g_first
      assign v_c    = vld_i;
      assign rem_c  = '0;
      assign root_c = '0;
      assign op_c   = IWE'(rad_i);
      assign sb_c   = sb_i;
    end else begin : g_next
      assign v_c    = v_r[s];
      assign rem_c  = rem_r[s];
      assign root_c = root_r[s];
      assign op_c   = op_r[s];
      assign sb_c   = sb_r[s];
    end

    // bring down the next two radicand bits, try 4*root+1
    always_comb begin
      rem_sh = {rem_c[RMW-3:0], op_c[IWE-1 -: 2]};
      trial  = {root_c, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_c[OW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_c[OW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= rem_nxt;
        root_r[s+1] <= root_nxt;
        op_r[s+1]   <= op_c << 2;
        sb_r[s+1]   <= sb_c;
      end
    end
  end

  assign vld_o  = v_r[OW];
  assign root_o = root_r[OW];
  assign sb_o   = sb_r[OW];

endmodule

// ===== src/cov_div.sv =====
// ----------------------------------------------------------------------------
// cov_div: pipelined restoring divider with overflow detect
// First stage flags a quotient of 2^QBW or more, then one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module cov_div #(
  parameter int NW  = 88,
  parameter int DNW = 64,
  parameter int QBW = 31,
  parameter int SBW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [NW-1:0]   num_i,
  input  logic [DNW-1:0]  den_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            vld_o,
  output logic [QBW-1:0]  quo_o,
  output logic            ovf_o,
  output logic [SBW-1:0]  sb_o
);

  localparam int RW = (NW > DNW + QBW) ? NW : DNW + QBW + 1;
  localparam int NS = QBW + 1;

  logic             v_r   [1:NS];
  logic [RW-1:0]    rem_r [1:NS];
  logic [DNW-1:0]   den_r [1:NS];
  logic [QBW-1:0]   quo_r [1:NS];
  logic             ovf_r [1:NS];
  logic [SBW-1:0]   sb_r  [1:NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic             v_c, ovf_c, ovf_nxt;
    logic [RW-1:0]    rem_c, rem_nxt, dsh;
    logic [DNW-1:0]   den_c;
    logic [QBW-1:0]   quo_c, quo_nxt;
    logic [SBW-1:0]   sb_c;

    if (s == 0) begin : g_first
      assign v_c   = vld_i;
      assign rem_c = RW'(num_i);
      assign den_c = den_i;
      assign quo_c = '0;
      assign ovf_c = 1'b0;
      assign sb_c  = sb_i;
      assign dsh   = RW'(den_c) << QBW;
      always_comb begin
        ovf_nxt = (rem_c >= dsh);
        rem_nxt = rem_c;
        quo_nxt = quo_c;
      end
    end else begin : g_next
      assign v_c   = v_r[s];
      assign rem_c = rem_r[s];
      assign den_c = den_r[s];
      assign quo_c = quo_r[s];
      assign ovf_c = ovf_r[s];
      assign sb_c  = sb_r[s];
      assign dsh   = RW'(den_c) << (QBW - s);
      always_comb begin
        ovf_nxt = ovf_c;
        if (rem_c >= dsh) begin
          rem_nxt = rem_c - dsh;
          quo_nxt = quo_c | (QBW'(1) << (QBW - s));
        end else begin
          rem_nxt = rem_c;
          quo_nxt = quo_c;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_nxt;
        den_r[s+1] <= den_c;
        quo_r[s+1] <= quo_nxt;
        ovf_r[s+1] <= ovf_nxt;
        sb_r[s+1]  <= sb_c;
      end
    end
  end

  assign vld_o = v_r[NS];
  assign quo_o = quo_r[NS];
  assign ovf_o = ovf_r[NS];
  assign sb_o  = sb_r[NS];

endmodule

// ===== src/circular_orbit_velocity_unit.sv =====
// ----------------------------------------------------------------------------
// circular_orbit_velocity_unit: tangential velocity of a disk particle
// Takes a signed Q16.16 position (x, y) per word and returns the circular
// orbit velocity (-y*v/r, x*v/r), v = sqrt(G*M*r)/R, saturated to 32 bits.
//
// Usage: in_* and out_* are valid/ready channels carrying one word each.
// One word is taken every cycle while the two-entry output buffer is not
// full. The rate comes from the pipeline: squares, the radius root
// (32 stages), two multiplies, the velocity roots (88 stages, one bit each)
// and the dividers (32 stages), all advancing together.
// A two-entry output buffer keeps input open while a result waits; once its
// second entry fills, the whole pipeline holds until out_ready returns.
// cfg_we writes grav_const, central_mass or disk_radius (index 0..2);
// write only while the pipeline is empty. Reset clears all valid
// bits and sets each register to 1.0 (65536). disk_radius 0 acts as 1 LSB.
// ----------------------------------------------------------------------------
module circular_orbit_velocity_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cov_pkg::cov_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cov_pkg::cov_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [cov_pkg::COV_IDXW-1:0]      cfg_idx,
  input  logic [cov_pkg::COV_DW-1:0]        cfg_data
);

  localparam int DW  = cov_pkg::COV_DW;
  localparam int FB  = cov_pkg::COV_FB;
  localparam int SQW = 2 * DW;
  localparam int GMW = 2 * DW;
  localparam int CMW = 3 * DW;
  localparam int CW  = CMW + FB;
  localparam int DNW = 2 * DW;
  localparam int QW  = SQW + CW;
  localparam int RTW = (QW + QW % 2) / 2;
  localparam int QBW = DW - 1;
  localparam int FLW = $bits(cov_pkg::cov_flags_t);

  // configuration
  logic [DW-1:0]  grav_r, mass_r, drad_r, deff_r;
  logic [GMW-1:0] gm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= cov_pkg::COV_REG_RESET;
      mass_r <= cov_pkg::COV_REG_RESET;
      drad_r <= cov_pkg::COV_REG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cov_pkg::COV_REG_GRAV: grav_r <= cfg_data;
        cov_pkg::COV_REG_MASS: mass_r <= cfg_data;
        cov_pkg::COV_REG_DRAD: drad_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    gm_r   <= grav_r * mass_r;
    deff_r <= (drad_r == '0) ? DW'(1) : drad_r;
  end

  // output buffer state decides whether the pipeline advances
  logic             en;
  logic             out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic             push, pop, ld_res, ld_skid, skid_ld;
  cov_pkg::cov_out_t out_r, skid_r, res;

  assign en       = !skid_v_r;
  assign in_ready = en;

  // stage A: magnitudes and flags
  logic [DW-1:0]       xm_nxt, ym_nxt, xm_r, ym_r;
  cov_pkg::cov_flags_t fa_nxt, fa_r;
  logic                va_r;

  always_comb begin
    xm_nxt     = in_data.pos_x[DW-1] ? (~in_data.pos_x + DW'(1)) : in_data.pos_x;
    ym_nxt     = in_data.pos_y[DW-1] ? (~in_data.pos_y + DW'(1)) : in_data.pos_y;
    fa_nxt.nx   = in_data.pos_x[DW-1];
    fa_nxt.ny   = (ym_nxt != '0) && !in_data.pos_y[DW-1];
    fa_nxt.mx0  = (xm_nxt == '0);
    fa_nxt.my0  = (ym_nxt == '0);
    fa_nxt.last = in_data.last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xm_r <= xm_nxt;
      ym_r <= ym_nxt;
      fa_r <= fa_nxt;
    end
  end

  // squares
  logic                vsq;
  logic [SQW-1:0]      xx_a, yy_a;
  logic [FLW-1:0]      fsq;

  cov_mul #(.AW(DW), .BW(DW), .PW(DW), .SBW(FLW)) u_mul_xx (
    .clk, .rst_n, .en, .vld_i(va_r), .a_i(xm_r), .b_i(xm_r), .sb_i(fa_r),
    .vld_o(vsq), .p_o(xx_a), .sb_o(fsq)
  );

  cov_mul #(.AW(DW), .BW(DW), .PW(DW), .SBW(1)) u_mul_yy (
    .clk, .rst_n, .en, .vld_i(va_r), .a_i(ym_r), .b_i(ym_r), .sb_i(fa_r.my0),
    .vld_o(), .p_o(yy_a), .sb_o()
  );

  // stage B: sum of squares
  logic                vb_r;
  logic [SQW-1:0]      s_r, xx_r, yy_r;
  logic [FLW-1:0]      fb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= vsq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r  <= xx_a + yy_a;
      xx_r <= xx_a;
      yy_r <= yy_a;
      fb_r <= fsq;
    end
  end

  // radius
  logic                vc;
  logic [DW-1:0]       rr_c;
  logic [SQW-1:0]      xx_c, yy_c;
  logic [FLW-1:0]      fc;
  logic                zr_c;

  cov_sqrt #(.IW(SQW), .SBW(2*SQW+FLW)) u_sqrt_r (
    .clk, .rst_n, .en, .vld_i(vb_r), .rad_i(s_r), .sb_i({xx_r, yy_r, fb_r}),
    .vld_o(vc), .root_o(rr_c), .sb_o({xx_c, yy_c, fc})
  );

  assign zr_c = (rr_c == '0);

  // denominator R*r and numerator core G*M*r
  logic                vd, zr_d;
  logic [DNW-1:0]      den_d;
  logic [CMW-1:0]      cm_d;
  logic [CW-1:0]       cm_sh;
  logic [SQW-1:0]      xx_d, yy_d;
  logic [FLW-1:0]      fd;

  cov_mul #(.AW(DW), .BW(DW), .PW(DW), .SBW(SQW+1+FLW)) u_mul_den (
    .clk, .rst_n, .en, .vld_i(vc), .a_i(deff_r), .b_i(rr_c),
    .sb_i({xx_c, zr_c, fc}),
    .vld_o(vd), .p_o(den_d), .sb_o({xx_d, zr_d, fd})
  );

  cov_mul #(.AW(GMW), .BW(DW), .PW(DW), .SBW(SQW)) u_mul_cm (
    .clk, .rst_n, .en, .vld_i(vc), .a_i(gm_r), .b_i(rr_c), .sb_i(yy_c),
    .vld_o(), .p_o(cm_d), .sb_o(yy_d)
  );

  assign cm_sh = {cm_d, {FB{1'b0}}};

  // radicands mag^2 * G*M*r*2^FB
  logic                ve, zr_e;
  logic [QW-1:0]       qx_e, qy_e;
  logic [DNW-1:0]      den_e;
  logic [FLW-1:0]      fe;

  cov_mul #(.AW(CW), .BW(SQW), .PW(DW), .SBW(DNW+1+FLW)) u_mul_qx (
    .clk, .rst_n, .en, .vld_i(vd), .a_i(cm_sh), .b_i(xx_d),
    .sb_i({den_d, zr_d, fd}),
    .vld_o(ve), .p_o(qx_e), .sb_o({den_e, zr_e, fe})
  );

  cov_mul #(.AW(CW), .BW(SQW), .PW(DW), .SBW(1)) u_mul_qy (
    .clk, .rst_n, .en, .vld_i(vd), .a_i(cm_sh), .b_i(yy_d), .sb_i(zr_d),
    .vld_o(), .p_o(qy_e), .sb_o()
  );

  // roots
  logic                vf, zr_f;
  logic [RTW-1:0]      rtx_f, rty_f;
  logic [DNW-1:0]      den_f;
  logic [FLW-1:0]      ff;

  cov_sqrt #(.IW(QW), .SBW(DNW+1+FLW)) u_sqrt_qx (
    .clk, .rst_n, .en, .vld_i(ve), .rad_i(qx_e), .sb_i({den_e, zr_e, fe}),
    .vld_o(vf), .root_o(rtx_f), .sb_o({den_f, zr_f, ff})
  );

  cov_sqrt #(.IW(QW), .SBW(1)) u_sqrt_qy (
    .clk, .rst_n, .en, .vld_i(ve), .rad_i(qy_e), .sb_i(zr_e),
    .vld_o(), .root_o(rty_f), .sb_o()
  );

  // quotients
  logic                vg, zr_g, ovx_g, ovy_g;
  logic [QBW-1:0]      qx_g, qy_g;
  cov_pkg::cov_flags_t fg;

  cov_div #(.NW(RTW), .DNW(DNW), .QBW(QBW), .SBW(1+FLW)) u_div_x (
    .clk, .rst_n, .en, .vld_i(vf), .num_i(rtx_f), .den_i(den_f),
    .sb_i({zr_f, ff}),
    .vld_o(vg), .quo_o(qx_g), .ovf_o(ovx_g), .sb_o({zr_g, fg})
  );

  cov_div #(.NW(RTW), .DNW(DNW), .QBW(QBW), .SBW(1)) u_div_y (
    .clk, .rst_n, .en, .vld_i(vf), .num_i(rty_f), .den_i(den_f), .sb_i(zr_f),
    .vld_o(), .quo_o(qy_g), .ovf_o(ovy_g), .sb_o()
  );

  // apply sign, saturate, force zero
  function automatic logic [DW-1:0] fold(input logic [QBW-1:0] q, input logic ovf,
                                         input logic neg, input logic zero);
    logic [DW-1:0] m;
    m = {1'b0, q};
    if (zero) begin
      return '0;
    end else if (ovf) begin
      return neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return neg ? (~m + DW'(1)) : m;
  endfunction

  always_comb begin
    res.vel_x    = fold(qy_g, ovy_g, fg.ny, zr_g || fg.my0);
    res.vel_y    = fold(qx_g, ovx_g, fg.nx, zr_g || fg.mx0);
    res.last_out = fg.last;
  end

  // two-entry output buffer
  assign push = en && vg;
  assign pop  = out_v_r && out_ready;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    ld_res     = 1'b0;
    ld_skid    = 1'b0;
    skid_ld    = 1'b0;
    if (skid_v_r) begin
      if (pop) begin
        ld_skid    = 1'b1;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        ld_res    = 1'b1;
        out_v_nxt = 1'b1;
      end else begin
        skid_ld    = 1'b1;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_skid) begin
      out_r <= skid_r;
    end else if (ld_res) begin
      out_r <= res;
    end
    if (skid_ld) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
